@@ rtl/core/audio_rms_peak_meter_core_assert.svh @@
// Assertion macros for the level meter core.
// Expects clk_i and rst_ni to be visible where the macros are used.
`ifndef AUDIO_RMS_PEAK_METER_CORE_ASSERT_SVH
`define AUDIO_RMS_PEAK_METER_CORE_ASSERT_SVH

// Property checked on every clock edge, disabled while in reset.
`define ARPM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define ARPM_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/core/arpm_pkg.sv @@
// Shared types and constants for the RMS / peak level meter.
// No dependencies.
package arpm_pkg;

  localparam int unsigned RAW_W      = 32;
  localparam int unsigned SHIFT      = 8;
  localparam int unsigned SAMPLE_W   = RAW_W - SHIFT;  // 24-bit audio sample
  localparam int unsigned SQUARE_W   = 47;             // holds 2**46, the largest square
  localparam int unsigned MEAN_W     = 48;             // even width for the root recurrence
  localparam int unsigned ROOT_STEPS = MEAN_W / 2;
  localparam int unsigned COUNT_W    = 9;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_word;
    logic                    window_end;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] rms_level;
    logic [SAMPLE_W-1:0] peak_level;
    logic [COUNT_W-1:0]  window_count;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic take;        // register sample magnitude, peak, tally
    logic square;      // register mag * mag
    logic accum;       // add square to running sum
    logic div_init;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic load_out;    // load result register, clear window state
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic close;       // last taken item closes the window
  } stat_t;

endpackage

@@ rtl/core/audio_rms_peak_meter_core.sv @@
// Channel   Dir  Handshake                  Payload
// in        in   in_valid_i / in_ready_o    arpm_pkg::in_t  (raw_word, window_end)
// out       out  out_valid_o / out_ready_i  arpm_pkg::out_t (rms_level, peak_level, window_count)
//
// An item that does not close its window goes through magnitude, square and accumulate steps.
// An item that closes the window then runs the bit-serial divider over SUM_W bits and the
// 2-bit-per-step root (SUM_W = 47 + clog2(WINDOW_MAX+1)).
// The result register lets intake resume while a result waits; a full result register
// stalls only the next window close. Reset clears window state and the sequencer.
module audio_rms_peak_meter_core #(
  parameter int unsigned WINDOW_MAX = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  arpm_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output arpm_pkg::out_t out_data_o
);
  import arpm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  arpm_ctrl #(.WINDOW_MAX(WINDOW_MAX)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  arpm_dp #(.WINDOW_MAX(WINDOW_MAX)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

@@ rtl/core/arpm_ctrl.sv @@
// Sequencer for the level meter: item intake, divide and root steps, result hand-off.
// Depends on arpm_pkg.
module arpm_ctrl #(
  parameter int unsigned WINDOW_MAX = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output arpm_pkg::cmd_t cmd_o,
  input  arpm_pkg::stat_t stat_i
);
  import arpm_pkg::*;

  localparam int unsigned CW    = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SUM_W = SQUARE_W + CW;
  localparam int unsigned CNT_W = $clog2(SUM_W);

  typedef enum logic [3:0] {
    S_IDLE, S_SQUARE, S_ACCUM, S_DIV_INIT, S_DIV, S_SQRT_INIT, S_SQRT, S_FINISH
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             load_ok;

  assign load_ok     = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.take      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.square    = (state_q == S_SQUARE);
    cmd_o.accum     = (state_q == S_ACCUM);
    cmd_o.div_init  = (state_q == S_DIV_INIT);
    cmd_o.div_step  = (state_q == S_DIV);
    cmd_o.sqrt_init = (state_q == S_SQRT_INIT);
    cmd_o.sqrt_step = (state_q == S_SQRT);
    cmd_o.load_out  = (state_q == S_FINISH) && load_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_SQUARE;
          end
        end
        S_SQUARE: state_q <= S_ACCUM;
        S_ACCUM: begin
          state_q <= stat_i.close ? S_DIV_INIT : S_IDLE;
        end
        S_DIV_INIT: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(SUM_W - 1)) begin
            state_q <= S_SQRT_INIT;
          end
        end
        S_SQRT_INIT: begin
          cnt_q   <= '0;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(ROOT_STEPS - 1)) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (load_ok) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/arpm_dp.sv @@
// Datapath for the level meter: magnitude, square, sum, restoring divider,
// digit-by-digit square root and the result register. Depends on arpm_pkg.
module arpm_dp #(
  parameter int unsigned WINDOW_MAX = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  arpm_pkg::in_t   in_data_i,
  input  arpm_pkg::cmd_t  cmd_i,
  output arpm_pkg::stat_t stat_o,
  output arpm_pkg::out_t  out_data_o
);
  import arpm_pkg::*;

  localparam int unsigned CW    = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SUM_W = SQUARE_W + CW;
  localparam int unsigned RR_W  = SAMPLE_W + 1;  // root remainder stays <= 2 * root

  // window state
  logic [SAMPLE_W-1:0]   mag_q, peak_q;
  logic [CW-1:0]         tally_q;
  logic                  close_q;
  logic [2*SAMPLE_W-1:0] sq_q;
  logic [SUM_W-1:0]      sum_q;

  // divider
  logic [SUM_W-1:0]      dvd_q;   // dividend shifts out, quotient shifts in
  logic [CW-1:0]         rem_q;

  // square root
  logic [MEAN_W-1:0]     x_q;
  logic [RR_W-1:0]       rr_q;
  logic [SAMPLE_W-1:0]   root_q;

  out_t                  out_q;

  logic [SAMPLE_W-1:0]   sample, mag;
  logic [CW-1:0]         tally_nxt;
  logic [CW:0]           trial;
  logic                  div_ge;
  logic [CW:0]           div_diff;
  logic [RR_W+1:0]       rr_shift, rr_trial, rr_diff;
  logic                  root_ge;
  logic [CW+COUNT_W-1:0] count_ext;

  assign sample    = in_data_i.raw_word[RAW_W-1:SHIFT];
  // two's complement magnitude; the most negative sample maps to 2**23
  assign mag       = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
  assign tally_nxt = tally_q + 1'b1;

  assign trial     = {rem_q, dvd_q[SUM_W-1]};
  assign div_ge    = trial >= {1'b0, tally_q};
  assign div_diff  = trial - {1'b0, tally_q};

  assign rr_shift  = {rr_q, x_q[MEAN_W-1 -: 2]};
  assign rr_trial  = {1'b0, root_q, 2'b01};
  assign root_ge   = rr_shift >= rr_trial;
  assign rr_diff   = rr_shift - rr_trial;

  assign count_ext = {{COUNT_W{1'b0}}, tally_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q  <= '0;
      tally_q <= '0;
      sum_q   <= '0;
      close_q <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        if (mag > peak_q) begin
          peak_q <= mag;
        end
        tally_q <= tally_nxt;
        close_q <= in_data_i.window_end || (tally_nxt >= CW'(WINDOW_MAX));
      end
      if (cmd_i.accum) begin
        sum_q <= sum_q + SUM_W'(sq_q[SQUARE_W-1:0]);
      end
      if (cmd_i.load_out) begin
        peak_q  <= '0;
        tally_q <= '0;
        sum_q   <= '0;
        close_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      mag_q <= mag;
    end
    if (cmd_i.square) begin
      sq_q <= mag_q * mag_q;
    end
    if (cmd_i.div_init) begin
      dvd_q <= sum_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[SUM_W-2:0], div_ge};
      rem_q <= div_ge ? div_diff[CW-1:0] : trial[CW-1:0];
    end
    // mean never exceeds 2**46, so the upper quotient bits are zero
    if (cmd_i.sqrt_init) begin
      x_q    <= dvd_q[MEAN_W-1:0];
      rr_q   <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      x_q    <= {x_q[MEAN_W-3:0], 2'b00};
      rr_q   <= root_ge ? rr_diff[RR_W-1:0] : rr_shift[RR_W-1:0];
      root_q <= {root_q[SAMPLE_W-2:0], root_ge};
    end
    if (cmd_i.load_out) begin
      out_q.rms_level    <= root_q;
      out_q.peak_level   <= peak_q;
      out_q.window_count <= count_ext[COUNT_W-1:0];
    end
  end

  assign stat_o.close = close_q;
  assign out_data_o   = out_q;

endmodule

@@ rtl/core/arpm_checker.sv @@
// Port-level checks for the level meter core, bound to the top level.
// Depends on arpm_pkg and audio_rms_peak_meter_core_assert.svh.
`include "audio_rms_peak_meter_core_assert.svh"

module arpm_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input arpm_pkg::out_t out_data_o
);
  import arpm_pkg::*;

  `ARPM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_data_o), "result dropped or changed while stalled")

  `ARPM_ASSERT(a_levels, !out_valid_o || ((out_data_o.peak_level <= 24'd8388608) &&
    (out_data_o.rms_level <= out_data_o.peak_level)), "rms above peak or peak out of range")

  `ARPM_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o,
    "second item taken while one is in work")

  `ARPM_ASSERT(a_result_src, !$rose(out_valid_o) || $past(!in_ready_o),
    "result appeared without a window close in work")

endmodule

bind audio_rms_peak_meter_core arpm_checker u_arpm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

@@ test/audio_rms_peak_meter_core_test.sv @@
`timescale 1ns / 1ps
// Testbench for audio_rms_peak_meter_core: sends raw I2S words and checks the
// window results against a predictor that runs alongside. Depends on arpm_pkg.
module audio_rms_peak_meter_core_test;

  localparam int unsigned WINDOW_MAX    = 256;
  localparam int unsigned RANDOM_ITEMS  = 150;
  localparam int unsigned HOLD_CYCLES   = 500;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned IDLE_PCT      = 14;

  logic           clk = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready_o;
  arpm_pkg::in_t  in_data = '0;
  logic           out_valid_o;
  logic           out_ready = 1'b0;
  arpm_pkg::out_t out_data_o;

  // Predictor state for the window being accumulated
  longint unsigned acc_square_sum = 0;
  logic [23:0]     acc_peak = '0;
  int unsigned     acc_tally = 0;

  arpm_pkg::out_t  expected_meters[$];
  int unsigned     mismatch_count = 0;

  bit              idle_on = 1'b1;
  bit              hold_go = 1'b0;
  int unsigned     hold_left = 0;

  audio_rms_peak_meter_core #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  always #1 clk = ~clk;

  initial begin
    #1000000;
    $display("== FAIL ==");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic note_failure(input string msg);
    if (mismatch_count < 10) $display("%s", msg);
    mismatch_count++;
  endtask

  // Sampled mid-cycle: the item is taken at the next rising edge
  always @(negedge clk) begin : check_results
    arpm_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_meters.size() == 0) begin
        note_failure($sformatf("unexpected result: rms %0d peak %0d count %0d",
                               out_data_o.rms_level, out_data_o.peak_level,
                               out_data_o.window_count));
      end else begin
        want = expected_meters.pop_front();
        if (out_data_o.rms_level !== want.rms_level ||
            out_data_o.peak_level !== want.peak_level ||
            out_data_o.window_count !== want.window_count) begin
          note_failure($sformatf(
            "mismatch: rms exp %0d got %0d, peak exp %0d got %0d, count exp %0d got %0d",
            want.rms_level, out_data_o.rms_level, want.peak_level,
            out_data_o.peak_level, want.window_count, out_data_o.window_count));
        end
      end
    end
  end

  // Floor square root, one result bit at a time from the top
  function automatic logic [23:0] floor_root(input longint unsigned v);
    logic [23:0]     r;
    longint unsigned rr;
    r = '0;
    for (int b = 23; b >= 0; b--) begin
      r[b] = 1'b1;
      rr = r;
      if (rr * rr > v) r[b] = 1'b0;
    end
    return r;
  endfunction

  function automatic void predict_level(input arpm_pkg::in_t item);
    logic signed [23:0] sample;
    logic [23:0]        mag;
    longint unsigned    wide_mag;
    arpm_pkg::out_t     res;
    sample = item.raw_word[31:8];
    // full-scale negative gives 0x800000, still fits unsigned
    mag = sample[23] ? (~sample + 1'b1) : sample;
    wide_mag = mag;
    if (mag > acc_peak) acc_peak = mag;
    acc_square_sum += wide_mag * wide_mag;
    acc_tally++;
    if (item.window_end || acc_tally >= WINDOW_MAX) begin
      res.rms_level    = floor_root(acc_square_sum / acc_tally);
      res.peak_level   = acc_peak;
      res.window_count = acc_tally[8:0];
      expected_meters.push_back(res);
      acc_square_sum = 0;
      acc_peak = '0;
      acc_tally = 0;
    end
  endfunction

  // Called at a rising edge; returns at the edge where the item was taken
  task automatic send_sample(input logic [31:0] raw, input logic last);
    arpm_pkg::in_t item;
    bit            took;
    item.raw_word   = raw;
    item.window_end = last;
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do begin
      @(negedge clk);
      took = in_ready_o;
      @(posedge clk);
    end while (!took);
    predict_level(item);
  endtask

  task automatic drain_results();
    while (expected_meters.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_raw();
    logic [31:0] low_byte;
    low_byte = $urandom_range(255);
    case ($urandom_range(7))
      0: return 32'h8000_0000 | low_byte;
      1: return 32'h7FFF_FF00 | low_byte;
      2: return ($urandom_range(4095) << 8) | low_byte;
      3: return (-($urandom_range(4095) << 8)) ^ low_byte;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_extremes();
    // single-sample windows at the corners of the sample range
    send_sample(32'h8000_0000, 1'b1);
    send_sample(32'h7FFF_FFFF, 1'b1);
    send_sample(32'h0000_0000, 1'b1);
    send_sample(32'hFFFF_FFFF, 1'b1);
    send_sample(32'h0000_00FF, 1'b1);
    send_sample(32'h0000_0100, 1'b1);
    send_sample(32'hFFFF_FE00, 1'b1);
    // peak taken from the negative full-scale sample
    send_sample(32'h7FFF_FF00, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0000_0000, 1'b1);
    // mean that divides evenly but has no exact root, then one that does not divide evenly
    send_sample(32'h0000_0300, 1'b0);
    send_sample(32'h0000_0500, 1'b0);
    send_sample(32'hFFFF_F900, 1'b0);
    send_sample(32'h0000_0100, 1'b1);
    send_sample(32'hAAAA_AAAA, 1'b0);
    send_sample(32'h5555_5555, 1'b1);
  endtask

  task automatic test_window_max();
    // closes on count alone; largest possible sum and root
    for (int k = 0; k < WINDOW_MAX; k++) send_sample(32'h8000_0000 | k[7:0], 1'b0);
    // count and end mark both reached on the same sample
    for (int k = 0; k < WINDOW_MAX; k++) send_sample(pick_raw(), k == WINDOW_MAX - 1);
    // runs past the limit: splits into a full window and a short one
    for (int k = 0; k < WINDOW_MAX + 20; k++) send_sample(pick_raw(), k == WINDOW_MAX + 19);
  endtask

  task automatic test_output_backpressure();
    in_valid <= 1'b0;
    drain_results();
    @(negedge clk);
    hold_go = 1'b1;
    @(posedge clk);
    for (int k = 0; k < 60; k++) send_sample(pick_raw(), $urandom_range(1));
    send_sample(pick_raw(), 1'b1);
    // sender stays quiet until every result is out
    in_valid <= 1'b0;
    drain_results();
    @(posedge clk);
  endtask

  task automatic test_random_windows();
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_on = !(sent < 100);
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_sample(pick_raw(), $urandom_range(1));
        sent++;
      end else begin
        len = (pick < 14) ? $urandom_range(200, 300) : $urandom_range(1, 16);
        for (int unsigned k = 0; k < len; k++) begin
          send_sample(pick_raw(), k == len - 1);
          sent++;
        end
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_window_max();
    test_output_backpressure();
    test_random_windows();
    in_valid <= 1'b0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_meters.size() != 0) begin
      note_failure($sformatf("%0d expected results never arrived", expected_meters.size()));
    end
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
